@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DMN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DMN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dmn_pkg.sv @@
// ----------------------------------------------------------------------------
// Mutual exclusion node package
// Operation, result and state codes shared by the node's modules.
// ----------------------------------------------------------------------------
package dmn_pkg;

  localparam int IdW    = 8;
  localparam int InSeqW = 16;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;

  typedef enum logic [2:0] {
    OP_REQUEST = 3'd0,
    OP_REPLY   = 3'd1,
    OP_WANT    = 3'd2,
    OP_RELEASE = 3'd3,
    OP_JOIN    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    K_REQUEST = 2'd0,
    K_REPLY   = 2'd1,
    K_GRANT   = 2'd2,
    K_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MY_ID        = 1'b0,
    CFG_INIT_HIGHEST = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    op_e            op;
    logic [IdW-1:0] peer;
    logic           defer;
    logic           found;
  } bcast_t;

  // Report from a cell; only the cell holding the token drives it.
  typedef struct packed {
    logic           emit;
    logic           is_req;
    logic [IdW-1:0] dest;
    logic           hit;
  } cell_out_t;

endpackage

@@ hdl/dmn_cell.sv @@
// ----------------------------------------------------------------------------
// Peer cell
// Holds one peer table slot and its deferred flag, and passes the walk
// token on to the next slot.
// ----------------------------------------------------------------------------
module dmn_cell
  import dmn_pkg::*;
#(
  parameter int IDX  = 1,
  parameter int NC_W = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_i,
  output logic            tok_o,
  input  bcast_t          bc_i,
  input  logic [NC_W-1:0] nc_i,
  input  logic            join_we_i,
  input  logic [IdW-1:0]  join_id_i,
  output cell_out_t       co_o
);

  logic           tok_q;
  logic           def_q, def_d;
  logic [IdW-1:0] id_q;
  logic           live, act, hit, wr;

  assign live = NC_W'(IDX) < nc_i;
  assign act  = tok_q && live;
  assign hit  = act && (bc_i.op == OP_REQUEST) && (id_q == bc_i.peer) && !bc_i.found;
  assign wr   = join_we_i && (nc_i == NC_W'(IDX));

  assign tok_o = tok_q && (NC_W'(IDX + 1) < nc_i);

  always_comb begin
    co_o        = '0;
    co_o.hit    = hit;
    co_o.dest   = act ? id_q : '0;
    co_o.is_req = act && (bc_i.op == OP_WANT);
    co_o.emit   = act && ((bc_i.op == OP_WANT) ||
                          ((bc_i.op == OP_RELEASE) && def_q) ||
                          (hit && !bc_i.defer));
  end

  always_comb begin
    def_d = def_q;
    if (wr) begin
      def_d = 1'b0;
    end else if (hit && bc_i.defer) begin
      def_d = 1'b1;
    end else if (act && (bc_i.op == OP_RELEASE)) begin
      def_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      def_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
      def_q <= def_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      id_q <= join_id_i;
    end
  end

endmodule

@@ hdl/dmn_ctrl.sv @@
// ----------------------------------------------------------------------------
// Node controller
// Holds the protocol state, launches walks along the cell chain and orders
// the results onto the output register.
// ----------------------------------------------------------------------------
module dmn_ctrl
  import dmn_pkg::*;
#(
  parameter int MAX_NODES = 16,
  parameter int SEQ_WIDTH = 16,
  parameter int NC_W      = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          operation_i,
  input  logic [IdW-1:0]      peer_id_i,
  input  logic [InSeqW-1:0]   seq_num_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  cell_out_t           co_i,
  output logic                launch_o,
  output bcast_t              bc_o,
  output logic [NC_W-1:0]     nc_o,
  output logic                join_we_o,
  output logic                out_strobe_o,
  output logic [1:0]          kind_o,
  output logic [IdW-1:0]      dest_id_o,
  output logic [InSeqW-1:0]   out_seq_o,
  output logic                last_o
);

  localparam int XW = (SEQ_WIDTH > InSeqW) ? SEQ_WIDTH : InSeqW;
  localparam logic [SEQ_WIDTH-1:0] SeqMax = {SEQ_WIDTH{1'b1}};

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [IdW-1:0]         peer_q, peer_d;
  logic                   defer_q, defer_d;
  logic                   found_q, found_d;
  logic                   req_q, req_d;
  logic [SEQ_WIDTH-1:0]   own_q, own_d;
  logic [SEQ_WIDTH-1:0]   high_q, high_d;
  logic [NC_W-1:0]        outst_q, outst_d;
  logic [NC_W-1:0]        nc_q, nc_d;
  logic [NC_W-1:0]        pos_q, pos_d;
  logic [IdW-1:0]         my_id_q, my_id_d;
  logic                   pend_vld_q, pend_vld_d;
  logic                   pend_req_q, pend_req_d;
  logic [IdW-1:0]         pend_dest_q, pend_dest_d;
  logic                   out_vld_q, out_vld_d;
  kind_e                  out_kind_q, out_kind_d;
  logic [IdW-1:0]         out_dest_q, out_dest_d;
  logic [SEQ_WIDTH-1:0]   out_seq_q, out_seq_d;
  logic                   out_last_q, out_last_d;
  logic [SEQ_WIDTH-1:0]   k_sat, cfg_sat, high_inc;

  function automatic logic [SEQ_WIDTH-1:0] sat_in(input logic [InSeqW-1:0] v);
    logic [XW-1:0] vx;
    logic [XW-1:0] mx;
    vx = XW'(v);
    mx = XW'(SeqMax);
    return (vx > mx) ? SeqMax : vx[SEQ_WIDTH-1:0];
  endfunction

  assign k_sat    = sat_in(seq_num_i);
  assign cfg_sat  = sat_in(cfg_data_i);
  assign high_inc = (high_q == SeqMax) ? high_q : high_q + SEQ_WIDTH'(1);

  assign busy         = (state_q != ST_IDLE);
  assign bc_o         = '{op: op_q, peer: peer_q, defer: defer_q, found: found_q};
  assign nc_o         = nc_q;
  assign out_strobe_o = out_vld_q;
  assign kind_o       = out_kind_q;
  assign dest_id_o    = out_dest_q;
  assign out_seq_o    = InSeqW'(out_seq_q);
  assign last_o       = out_last_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    peer_d      = peer_q;
    defer_d     = defer_q;
    found_d     = found_q;
    req_d       = req_q;
    own_d       = own_q;
    high_d      = high_q;
    outst_d     = outst_q;
    nc_d        = nc_q;
    pos_d       = pos_q;
    my_id_d     = my_id_q;
    pend_vld_d  = pend_vld_q;
    pend_req_d  = pend_req_q;
    pend_dest_d = pend_dest_q;
    out_vld_d   = 1'b0;
    out_kind_d  = out_kind_q;
    out_dest_d  = out_dest_q;
    out_seq_d   = out_seq_q;
    out_last_d  = out_last_q;
    launch_o    = 1'b0;
    join_we_o   = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MY_ID:        my_id_d = cfg_data_i[IdW-1:0];
        CFG_INIT_HIGHEST: high_d  = cfg_sat;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d    = op_e'(operation_i);
          peer_d  = peer_id_i;
          found_d = 1'b0;
          defer_d = req_q && ((k_sat > own_q) || ((k_sat == own_q) && (peer_id_i > my_id_q)));
          pos_d   = NC_W'(1);
          case (op_e'(operation_i))
            OP_REQUEST: begin
              if (k_sat > high_q) begin
                high_d = k_sat;
              end
              if (nc_q > NC_W'(1)) begin
                launch_o = 1'b1;
                state_d  = ST_WALK;
              end else begin
                state_d = ST_FINISH;
              end
            end
            OP_REPLY: begin
              if (req_q && (outst_q != '0)) begin
                outst_d = outst_q - NC_W'(1);
                if (outst_q == NC_W'(1)) begin
                  out_vld_d  = 1'b1;
                  out_kind_d = K_GRANT;
                  out_dest_d = '0;
                  out_seq_d  = own_q;
                  out_last_d = 1'b1;
                end
              end
            end
            OP_WANT: begin
              if (req_q) begin
                out_vld_d  = 1'b1;
                out_kind_d = K_ERROR;
                out_dest_d = peer_id_i;
                out_seq_d  = '0;
                out_last_d = 1'b1;
              end else begin
                req_d   = 1'b1;
                high_d  = high_inc;
                own_d   = high_inc;
                outst_d = nc_q - NC_W'(1);
                if (nc_q == NC_W'(1)) begin
                  out_vld_d  = 1'b1;
                  out_kind_d = K_GRANT;
                  out_dest_d = '0;
                  out_seq_d  = high_inc;
                  out_last_d = 1'b1;
                end else begin
                  launch_o = 1'b1;
                  state_d  = ST_WALK;
                end
              end
            end
            OP_RELEASE: begin
              req_d   = 1'b0;
              outst_d = '0;
              if (nc_q > NC_W'(1)) begin
                launch_o = 1'b1;
                state_d  = ST_WALK;
              end
            end
            OP_JOIN: begin
              if (nc_q >= NC_W'(MAX_NODES)) begin
                out_vld_d  = 1'b1;
                out_kind_d = K_ERROR;
                out_dest_d = peer_id_i;
                out_seq_d  = '0;
                out_last_d = 1'b1;
              end else begin
                join_we_o = 1'b1;
                nc_d      = nc_q + NC_W'(1);
              end
            end
            default: begin
              out_vld_d  = 1'b1;
              out_kind_d = K_ERROR;
              out_dest_d = peer_id_i;
              out_seq_d  = '0;
              out_last_d = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        found_d = found_q | co_i.hit;
        if (co_i.emit) begin
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_kind_d = pend_req_q ? K_REQUEST : K_REPLY;
            out_dest_d = pend_dest_q;
            out_seq_d  = own_q;
            out_last_d = 1'b0;
          end
          pend_vld_d  = 1'b1;
          pend_req_d  = co_i.is_req;
          pend_dest_d = co_i.dest;
        end
        if (pos_q == nc_q - NC_W'(1)) begin
          state_d = ST_FINISH;
        end else begin
          pos_d = pos_q + NC_W'(1);
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
        if (pend_vld_q) begin
          pend_vld_d = 1'b0;
          out_vld_d  = 1'b1;
          out_kind_d = pend_req_q ? K_REQUEST : K_REPLY;
          out_dest_d = pend_dest_q;
          out_seq_d  = own_q;
          out_last_d = 1'b1;
        end else if ((op_q == OP_REQUEST) && !found_q) begin
          out_vld_d  = 1'b1;
          out_kind_d = K_ERROR;
          out_dest_d = peer_q;
          out_seq_d  = '0;
          out_last_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      req_q      <= 1'b0;
      own_q      <= '0;
      high_q     <= '0;
      outst_q    <= '0;
      nc_q       <= NC_W'(1);
      my_id_q    <= IdW'(1);
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      pos_q      <= NC_W'(1);
    end else begin
      state_q    <= state_d;
      req_q      <= req_d;
      own_q      <= own_d;
      high_q     <= high_d;
      outst_q    <= outst_d;
      nc_q       <= nc_d;
      my_id_q    <= my_id_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      found_q    <= found_d;
      pos_q      <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    peer_q      <= peer_d;
    defer_q     <= defer_d;
    pend_req_q  <= pend_req_d;
    pend_dest_q <= pend_dest_d;
    out_kind_q  <= out_kind_d;
    out_dest_q  <= out_dest_d;
    out_seq_q   <= out_seq_d;
    out_last_q  <= out_last_d;
  end

endmodule

@@ hdl/distributed_mutex_node_top.sv @@
// ----------------------------------------------------------------------------
// Distributed mutual exclusion node
// One node of a sequence-number mutual exclusion protocol.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low. Reply received,
// peer join and refused or unknown events complete in the transfer cycle:
// their single result, if any, appears in the next cycle and busy stays low.
// Request received, want and release walk the peer slots, one slot per
// cycle along the chain of cells, then finish; busy is high throughout.
// With no peers a request only passes the finishing state, and a want or a
// release completes in the transfer cycle. Results leave one per cycle on
// out_strobe_o; each is held back in a pending register so that last_o marks
// the final result of the event. The receiver cannot stall. Configuration
// writes are to be taken only while the node is idle: the user must keep to
// this, as the block does not enforce it. Writing initial_highest loads the
// highest sequence number. Reset clears the protocol state, leaves the node
// alone with my_id 1 and needs no clearing pass: unused peer slots are never read.
// ----------------------------------------------------------------------------
module distributed_mutex_node_top
  import dmn_pkg::*;
#(
  parameter int MAX_NODES = 16,
  parameter int SEQ_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          operation_i,
  input  logic [IdW-1:0]      peer_id_i,
  input  logic [InSeqW-1:0]   seq_num_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_strobe_o,
  output logic [1:0]          kind_o,
  output logic [IdW-1:0]      dest_id_o,
  output logic [InSeqW-1:0]   out_seq_o,
  output logic                last_o
);

  localparam int NC_W = $clog2(MAX_NODES + 1);

  logic            tok [MAX_NODES-1];
  cell_out_t       co  [MAX_NODES-1];
  cell_out_t       co_all;
  bcast_t          bc;
  logic [NC_W-1:0] nc;
  logic            join_we;

  dmn_ctrl #(
    .MAX_NODES (MAX_NODES),
    .SEQ_WIDTH (SEQ_WIDTH),
    .NC_W      (NC_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .peer_id_i    (peer_id_i),
    .seq_num_i    (seq_num_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .co_i         (co_all),
    .launch_o     (tok[0]),
    .bc_o         (bc),
    .nc_o         (nc),
    .join_we_o    (join_we),
    .out_strobe_o (out_strobe_o),
    .kind_o       (kind_o),
    .dest_id_o    (dest_id_o),
    .out_seq_o    (out_seq_o),
    .last_o       (last_o)
  );

  for (genvar i = 1; i < MAX_NODES; i++) begin : g_cell
    if (i < MAX_NODES - 1) begin : g_mid
      dmn_cell #(.IDX(i), .NC_W(NC_W)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .tok_i     (tok[i-1]),
        .tok_o     (tok[i]),
        .bc_i      (bc),
        .nc_i      (nc),
        .join_we_i (join_we),
        .join_id_i (peer_id_i),
        .co_o      (co[i-1])
      );
    end else begin : g_end
      dmn_cell #(.IDX(i), .NC_W(NC_W)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .tok_i     (tok[i-1]),
        .tok_o     (),
        .bc_i      (bc),
        .nc_i      (nc),
        .join_we_i (join_we),
        .join_id_i (peer_id_i),
        .co_o      (co[i-1])
      );
    end
  end

  // Only the cell holding the token drives a non-zero report.
  always_comb begin
    co_all = '0;
    for (int i = 0; i < MAX_NODES - 1; i++) begin
      co_all = cell_out_t'(co_all | co[i]);
    end
  end

endmodule

@@ hdl/dmn_checker.sv @@
// ----------------------------------------------------------------------------
// Node port checker
// Watches the node's ports for busy, result ordering and result contents.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmn_checker
  import dmn_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [2:0]        operation_i,
  input logic              out_strobe_o,
  input logic [1:0]        kind_o,
  input logic [IdW-1:0]    dest_id_o,
  input logic [InSeqW-1:0] out_seq_o,
  input logic              last_o
);

  `DMN_ASSERT_NXT(a_short_event_idle, start && !busy && (operation_i == OP_REPLY || operation_i == OP_JOIN || operation_i > OP_JOIN), !busy, "short event raised busy")
  `DMN_ASSERT_NXT(a_no_spurious_result, !busy && !start, !out_strobe_o, "result without an event")
  `DMN_ASSERT_NXT(a_first_result_last, start && !busy, !out_strobe_o || last_o, "early result not marked last")
  `DMN_ASSERT_IMP(a_grant_error_form, out_strobe_o && (kind_o == K_GRANT || kind_o == K_ERROR), last_o && (kind_o == K_ERROR ? out_seq_o == '0 : dest_id_o == '0), "malformed grant or error")

endmodule

bind distributed_mutex_node_top dmn_checker u_dmn_checker (.*);
